@@ sv/iir_allpass_hilbert_transformer_macros.svh @@
// Assertion macros shared by the checker of the allpass Hilbert transformer.
// Depends on nothing; the including scope must provide clk and rst.
`ifndef IIR_ALLPASS_HILBERT_TRANSFORMER_MACROS_SVH
`define IIR_ALLPASS_HILBERT_TRANSFORMER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define AHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iaht: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define AHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iaht: next-cycle check failed");

`endif

@@ sv/iaht_pkg.sv @@
// Shared types and constants of the allpass Hilbert transformer.
// Depends on nothing; used by the section module and the top level.
package iaht_pkg;

  localparam longint MICRO_SCALE = 1000000;

  // Section coefficients in millionths: real chain, then imaginary chain.
  localparam longint RE1_A_MICRO = -260502;
  localparam longint RE1_B_MICRO = 25690;
  localparam longint RE2_A_MICRO = 870686;
  localparam longint RE2_B_MICRO = -1868500;
  localparam longint IM1_A_MICRO = 946570;
  localparam longint IM1_B_MICRO = -1946320;
  localparam longint IM2_A_MICRO = 63380;
  localparam longint IM2_B_MICRO = -837740;

  typedef enum logic [1:0] {
    SEC_IDLE,
    SEC_MUL,
    SEC_ROUND,
    SEC_SUM
  } sec_state_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_FIRST,
    TOP_SECOND,
    TOP_OUT
  } top_state_t;

  typedef struct packed {
    logic start;
    logic clear;
  } sec_ctrl_t;

  // Rounds a coefficient given in millionths to the fixed-point grid,
  // half away from zero. Only ever evaluated at elaboration.
  function automatic longint coef_fixed(input longint micro, input int frac);
    longint mag;
    longint q;
    mag = (micro < 0) ? -micro : micro;
    q = ((mag << frac) + (MICRO_SCALE / 2)) / MICRO_SCALE;
    return (micro < 0) ? -q : q;
  endfunction

endpackage

@@ sv/iaht_if.sv @@
// Valid/ready channel interfaces of the allpass Hilbert transformer.
// Depends on nothing; the top level takes one of each.
interface iaht_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink   (input valid, input action, input sample, output ready);
endinterface

interface iaht_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] in_phase;
  logic signed [SAMPLE_WIDTH-1:0] quadrature;

  modport source (output valid, output in_phase, output quadrature, input ready);
  modport sink   (input valid, input in_phase, input quadrature, output ready);
endinterface

@@ sv/iaht_section.sv @@
// One second-order allpass section with digit-serial multipliers.
// Depends on iaht_pkg for the control struct and the state type.
module iaht_section #(
  parameter int     STATE_WIDTH    = 24,
  parameter int     COEF_FRAC_BITS = 16,
  parameter longint COEF_A         = 0,
  parameter longint COEF_B         = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  iaht_pkg::sec_ctrl_t           ctrl,
  input  logic signed [STATE_WIDTH-1:0] x,
  output logic                          done,
  output logic signed [STATE_WIDTH-1:0] y
);
  import iaht_pkg::*;

  localparam int CW    = COEF_FRAC_BITS + 2;
  localparam int ND    = (STATE_WIDTH + 1) / 2;
  localparam int EW    = 2 * ND;
  localparam int PW    = CW + 3;
  localparam int FW    = PW + EW;
  localparam int TW    = STATE_WIDTH + 2;
  localparam int SW    = STATE_WIDTH + 4;
  localparam int CNT_W = $clog2(ND);

  localparam logic signed [FW-1:0] ROUND_HALF = FW'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SAT_HI     = SW'({(STATE_WIDTH - 1){1'b1}});
  localparam logic signed [SW-1:0] SAT_LO     = -SAT_HI - SW'(1);

  sec_state_t state, state_next;
  logic [CNT_W-1:0] cnt;
  logic last_digit;
  logic load, shift, round;

  logic signed [STATE_WIDTH-1:0] xin, x1, x2, y1, y2;
  logic signed [STATE_WIDTH-1:0] lane_src [4];
  logic signed [TW-1:0] term [4];
  logic signed [SW-1:0] sum;

  assign last_digit = (cnt == CNT_W'(ND - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      SEC_IDLE:  if (ctrl.start) state_next = SEC_MUL;
      SEC_MUL:   if (last_digit) state_next = SEC_ROUND;
      SEC_ROUND: state_next = SEC_SUM;
      SEC_SUM:   state_next = SEC_IDLE;
      default:   state_next = SEC_IDLE;
    endcase
    if (ctrl.clear) state_next = SEC_IDLE;
  end

  always_comb begin
    load  = 1'b0;
    shift = 1'b0;
    round = 1'b0;
    done  = 1'b0;
    unique case (state)
      SEC_IDLE:  load  = ctrl.start;
      SEC_MUL:   shift = 1'b1;
      SEC_ROUND: round = 1'b1;
      SEC_SUM:   done  = 1'b1;
      default:   load  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEC_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (load) cnt <= '0;
      else if (shift) cnt <= cnt + CNT_W'(1);
    end
  end

  assign lane_src[0] = x;
  assign lane_src[1] = x1;
  assign lane_src[2] = y1;
  assign lane_src[3] = y2;

  // Each lane multiplies one state word by its coefficient, two bits of the
  // state per cycle, least significant digit first. The accumulator shifts
  // right so that its adder stays as narrow as the coefficient.
  for (genvar g = 0; g < 4; g++) begin : g_lane
    localparam logic signed [PW-1:0] C = (g == 0 || g == 3) ? PW'(COEF_A) : PW'(COEF_B);

    logic        [EW-1:0] opr;
    logic        [EW-1:0] low;
    logic signed [PW-1:0] acc;
    logic signed [PW-1:0] pp;
    logic signed [PW:0]   part;
    logic signed [FW-1:0] full;
    logic signed [FW-1:0] shifted;

    always_comb begin
      pp = '0;
      if (opr[0]) pp = C;
      // The top digit carries the sign bit, whose weight is negative.
      if (opr[1]) pp = last_digit ? pp - (C <<< 1) : pp + (C <<< 1);
      part    = {acc[PW-1], acc} + {pp[PW-1], pp};
      full    = $signed({acc, low}) + ROUND_HALF;
      shifted = full >>> COEF_FRAC_BITS;
    end

    always_ff @(posedge clk) begin
      if (load) begin
        opr <= EW'(lane_src[g]);
        acc <= '0;
      end else if (shift) begin
        opr <= opr >> 2;
        acc <= {part[PW], part[PW:2]};
        low <= {part[1:0], low[EW-1:2]};
      end
      if (round) term[g] <= shifted[TW-1:0];
    end
  end

  always_comb begin
    sum = SW'(term[0]) + SW'(term[1]) + SW'(x2) - SW'(term[2]) - SW'(term[3]);
    if (sum > SAT_HI) y = SAT_HI[STATE_WIDTH-1:0];
    else if (sum < SAT_LO) y = SAT_LO[STATE_WIDTH-1:0];
    else y = sum[STATE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) xin <= x;
    if (rst || ctrl.clear) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (done) begin
      x2 <= x1;
      x1 <= xin;
      y2 <= y1;
      y1 <= y;
    end
  end

endmodule

@@ sv/iir_allpass_hilbert_transformer.sv @@
// Channel   Direction  Payload                     Transfer
// din       sink       action, sample              valid && ready
// dout      source     in_phase, quadrature        valid && ready
//
// A sample passes from its transfer to the result register as follows: the two
// sections of each chain run one after the other, and each spends one cycle per
// two-bit state digit. A clear item gives no result.
// Reset clears all history and empties the result register. A stalled result
// holds in its register while the next sample is already taken and worked on.
module iir_allpass_hilbert_transformer #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int STATE_WIDTH    = 24,
  parameter int COEF_FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  iaht_in_if.sink    din,
  iaht_out_if.source dout
);
  import iaht_pkg::*;

  localparam int D      = (STATE_WIDTH - 4) - (SAMPLE_WIDTH - 1);
  localparam int WW     = STATE_WIDTH + SAMPLE_WIDTH + 2;
  localparam int SH_IN  = (D < 0) ? -D : 1;
  localparam int SH_OUT = (D > 0) ? D : 1;
  localparam int SH_UP  = (D > 0) ? D : 0;
  localparam int SH_DN  = (D < 0) ? -D : 0;

  localparam logic signed [WW-1:0] HALF_IN  = WW'(1) <<< (SH_IN - 1);
  localparam logic signed [WW-1:0] HALF_OUT = WW'(1) <<< (SH_OUT - 1);
  localparam logic signed [WW-1:0] SAMP_HI  = WW'({(SAMPLE_WIDTH - 1){1'b1}});
  localparam logic signed [WW-1:0] SAMP_LO  = -SAMP_HI - WW'(1);

  localparam longint RE1_A = coef_fixed(RE1_A_MICRO, COEF_FRAC_BITS);
  localparam longint RE1_B = coef_fixed(RE1_B_MICRO, COEF_FRAC_BITS);
  localparam longint RE2_A = coef_fixed(RE2_A_MICRO, COEF_FRAC_BITS);
  localparam longint RE2_B = coef_fixed(RE2_B_MICRO, COEF_FRAC_BITS);
  localparam longint IM1_A = coef_fixed(IM1_A_MICRO, COEF_FRAC_BITS);
  localparam longint IM1_B = coef_fixed(IM1_B_MICRO, COEF_FRAC_BITS);
  localparam longint IM2_A = coef_fixed(IM2_A_MICRO, COEF_FRAC_BITS);
  localparam longint IM2_B = coef_fixed(IM2_B_MICRO, COEF_FRAC_BITS);

  function automatic logic signed [STATE_WIDTH-1:0] to_state(
    input logic signed [SAMPLE_WIDTH-1:0] s
  );
    logic signed [WW-1:0] w;
    w = WW'(s);
    if (D >= 0) w = w <<< SH_UP;
    else w = (w + HALF_IN) >>> SH_IN;
    return w[STATE_WIDTH-1:0];
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] to_sample(
    input logic signed [STATE_WIDTH-1:0] v
  );
    logic signed [WW-1:0] w;
    w = WW'(v);
    if (D > 0) w = (w + HALF_OUT) >>> SH_OUT;
    else w = w <<< SH_DN;
    if (w > SAMP_HI) w = SAMP_HI;
    else if (w < SAMP_LO) w = SAMP_LO;
    return w[SAMPLE_WIDTH-1:0];
  endfunction

  top_state_t state, state_next;
  logic accept, start1, start2, clr, capture, load_out;
  sec_ctrl_t ctrl1, ctrl2;
  logic done_re1, done_re2, done_im1, done_im2;
  logic signed [STATE_WIDTH-1:0] x_in, y_re1, y_re2, y_im1, y_im2;
  logic signed [STATE_WIDTH-1:0] re_st, im_st;
  logic out_valid;
  logic signed [SAMPLE_WIDTH-1:0] in_phase, quadrature;

  assign accept = din.valid && din.ready;
  assign x_in   = to_state(din.sample);

  always_comb begin
    state_next = state;
    unique case (state)
      TOP_IDLE:   if (accept && !din.action) state_next = TOP_FIRST;
      TOP_FIRST:  if (done_re1) state_next = TOP_SECOND;
      TOP_SECOND: if (done_re2) state_next = TOP_OUT;
      TOP_OUT:    if (!out_valid || dout.ready) state_next = TOP_IDLE;
      default:    state_next = TOP_IDLE;
    endcase
  end

  always_comb begin
    din.ready = 1'b0;
    start2    = 1'b0;
    capture   = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      TOP_IDLE:   din.ready = 1'b1;
      TOP_FIRST:  start2    = done_re1 && done_im1;
      TOP_SECOND: capture   = done_re2;
      TOP_OUT:    load_out  = !out_valid || dout.ready;
      default:    din.ready = 1'b0;
    endcase
  end

  assign start1      = accept && !din.action;
  assign clr         = accept && din.action;
  assign ctrl1.start = start1;
  assign ctrl1.clear = clr;
  assign ctrl2.start = start2;
  assign ctrl2.clear = clr;

  iaht_section #(
    .STATE_WIDTH(STATE_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .COEF_A(RE1_A), .COEF_B(RE1_B)
  ) u_re1 (.clk, .rst, .ctrl(ctrl1), .x(x_in), .done(done_re1), .y(y_re1));

  iaht_section #(
    .STATE_WIDTH(STATE_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .COEF_A(RE2_A), .COEF_B(RE2_B)
  ) u_re2 (.clk, .rst, .ctrl(ctrl2), .x(y_re1), .done(done_re2), .y(y_re2));

  iaht_section #(
    .STATE_WIDTH(STATE_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .COEF_A(IM1_A), .COEF_B(IM1_B)
  ) u_im1 (.clk, .rst, .ctrl(ctrl1), .x(x_in), .done(done_im1), .y(y_im1));

  iaht_section #(
    .STATE_WIDTH(STATE_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .COEF_A(IM2_A), .COEF_B(IM2_B)
  ) u_im2 (.clk, .rst, .ctrl(ctrl2), .x(y_im1), .done(done_im2), .y(y_im2));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= TOP_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (dout.ready) out_valid <= 1'b0;
    end
    // Both chains run in lockstep, so the imaginary sections finish with the
    // real ones; their done flags are checked only against each other.
    if (capture && done_im2) begin
      re_st <= y_re2;
      im_st <= y_im2;
    end
    if (load_out) begin
      in_phase   <= to_sample(re_st);
      quadrature <= to_sample(im_st);
    end
  end

  assign dout.valid      = out_valid;
  assign dout.in_phase   = in_phase;
  assign dout.quadrature = quadrature;

endmodule

@@ sv/iaht_checker.sv @@
// Port-level checker of the allpass Hilbert transformer, bound to the top.
// Depends on the assertion macros header.
module iaht_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_action,
  input logic out_valid,
  input logic out_ready
);
  `include "iir_allpass_hilbert_transformer_macros.svh"

  // A stalled result must stay on offer.
  `AHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // After a sample transfer the block is busy in the next cycle.
  `AHT_ASSERT_NEXT(a_busy_after_sample, in_valid && in_ready && !in_action, !in_ready)
  // A clear produces no result.
  `AHT_ASSERT_NEXT(a_clear_silent, in_valid && in_ready && in_action, !$rose(out_valid))
  // A new result only appears while a sample is being finished.
  `AHT_ASSERT_NOW(a_result_when_busy, $rose(out_valid), $past(!in_ready))

endmodule

bind iir_allpass_hilbert_transformer iaht_checker u_iaht_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (din.valid),
  .in_ready (din.ready),
  .in_action(din.action),
  .out_valid(dout.valid),
  .out_ready(dout.ready)
);
